[rtl/core/assert_macros.svh]
// Assertion helpers for the deque core.
// Both macros expect clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define DQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define DQ_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[rtl/core/dq_pkg.sv]
// ----------------------------------------------------------------------------
// dq_pkg
// Types, codes and sizes shared by the double-ended queue core.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned OPQ_DEPTH = 2;
  localparam int unsigned OPQ_PTR_W = $clog2(OPQ_DEPTH);
  localparam int unsigned OPQ_CNT_W = $clog2(OPQ_DEPTH + 1);

  typedef enum logic [2:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_CLEAR      = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    OP_PUSH_BACK,
    OP_PUSH_FRONT,
    OP_POP_BACK,
    OP_POP_FRONT,
    OP_CLEAR,
    OP_NOP
  } op_kind_e;

  typedef enum logic {
    BK_EXEC,
    BK_RESP
  } bk_state_e;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic [COUNT_W-1:0] count;
  } out_item_t;

  typedef struct packed {
    op_kind_e           kind;
    logic signed [31:0] value;
  } op_t;

endpackage

`default_nettype wire

[rtl/core/dq_front.sv]
// ----------------------------------------------------------------------------
// dq_front
// Input side: decodes the command code of each transfer into an operation.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_front (
  input  wire  dq_pkg::in_item_t in_i,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  output dq_pkg::op_t            op_o,
  output logic                   op_valid_o,
  input  wire                    op_ready_i
);
  import dq_pkg::*;

  always_comb begin
    op_o.value = in_i.value;
    case (in_i.cmd)
      CMD_PUSH_BACK:  op_o.kind = OP_PUSH_BACK;
      CMD_PUSH_FRONT: op_o.kind = OP_PUSH_FRONT;
      CMD_POP_BACK:   op_o.kind = OP_POP_BACK;
      CMD_POP_FRONT:  op_o.kind = OP_POP_FRONT;
      CMD_CLEAR:      op_o.kind = OP_CLEAR;
      default:        op_o.kind = OP_NOP;
    endcase
  end

  assign op_valid_o = in_valid_i;
  assign in_ready_o = op_ready_i;

endmodule

`default_nettype wire

[rtl/core/dq_op_queue.sv]
// ----------------------------------------------------------------------------
// dq_op_queue
// Short register queue of decoded operations between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_op_queue (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire  dq_pkg::op_t wr_op_i,
  input  wire         wr_valid_i,
  output logic        wr_ready_o,
  output dq_pkg::op_t rd_op_o,
  output logic        rd_valid_o,
  input  wire         rd_ready_i
);
  import dq_pkg::*;

  op_t                  slot_q [OPQ_DEPTH];
  logic [OPQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [OPQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [OPQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                 wr_en, rd_en;

  localparam logic [OPQ_PTR_W-1:0] PTR_LAST = OPQ_PTR_W'(OPQ_DEPTH - 1);

  assign wr_ready_o = (cnt_q != OPQ_CNT_W'(OPQ_DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_ready_i && rd_valid_o;
  assign rd_op_o    = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wr_ptr_q] <= wr_op_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/dq_back.sv]
// ----------------------------------------------------------------------------
// dq_back
// Execution side: ring indices, entry count, entry memory and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire  dq_pkg::op_t   op_i,
  input  wire                 op_valid_i,
  output logic                op_ready_o,
  output dq_pkg::out_item_t   out_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i
);
  import dq_pkg::*;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  bk_state_e          state_q, state_d;
  logic [IDX_W-1:0]   front_q, front_d;
  logic [IDX_W-1:0]   back_q, back_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  status_e            status_q, status_d;
  logic               exec;
  logic               load_out;

  logic               we;
  logic [IDX_W-1:0]   waddr;

  logic [31:0]        mem [DEPTH];
  logic [31:0]        rd_front_q, rd_back_q, wdata_q;
  logic               byp_front_q, byp_back_q;

  out_item_t          out_q;
  logic               out_valid_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_EXEC: if (op_valid_i && (!out_valid_q || out_ready_i)) state_d = BK_RESP;
      BK_RESP: state_d = BK_EXEC;
      default: state_d = BK_EXEC;
    endcase
  end

  // state outputs
  always_comb begin
    exec     = 1'b0;
    load_out = 1'b0;
    case (state_q)
      BK_EXEC: exec     = op_valid_i && (!out_valid_q || out_ready_i);
      BK_RESP: load_out = 1'b1;
      default: ;
    endcase
  end

  assign op_ready_o = exec;

  // operation datapath
  always_comb begin
    front_d  = front_q;
    back_d   = back_q;
    cnt_d    = cnt_q;
    status_d = ST_OK;
    we       = 1'b0;
    waddr    = back_q;
    case (op_i.kind)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (cnt_q == CNT_FULL) begin
          status_d = ST_FULL;
        end else if (cnt_q == '0) begin
          front_d = back_q;
          we      = 1'b1;
          waddr   = back_q;
          cnt_d   = CNT_W'(1);
        end else if (op_i.kind == OP_PUSH_BACK) begin
          back_d = (back_q == IDX_LAST) ? '0 : back_q + 1'b1;
          we     = 1'b1;
          waddr  = back_d;
          cnt_d  = cnt_q + 1'b1;
        end else begin
          front_d = (front_q == '0) ? IDX_LAST : front_q - 1'b1;
          we      = 1'b1;
          waddr   = front_d;
          cnt_d   = cnt_q + 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (cnt_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          cnt_d = cnt_q - 1'b1;
          if (cnt_q != CNT_W'(1)) back_d = (back_q == '0) ? IDX_LAST : back_q - 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (cnt_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          cnt_d = cnt_q - 1'b1;
          if (cnt_q != CNT_W'(1)) front_d = (front_q == IDX_LAST) ? '0 : front_q + 1'b1;
        end
      end
      OP_CLEAR: begin
        front_d = '0;
        back_d  = '0;
        cnt_d   = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_EXEC;
      front_q     <= '0;
      back_q      <= '0;
      cnt_q       <= '0;
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exec) begin
        front_q  <= front_d;
        back_q   <= back_d;
        cnt_q    <= cnt_d;
        status_q <= status_d;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // entry memory; read data of the same-cycle write is forwarded
  always_ff @(posedge clk_i) begin
    if (exec) begin
      if (we) begin
        mem[waddr] <= op_i.value;
      end
      rd_front_q  <= mem[front_d];
      rd_back_q   <= mem[back_d];
      byp_front_q <= we && (waddr == front_d);
      byp_back_q  <= we && (waddr == back_d);
      wdata_q     <= op_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.status <= status_q;
      out_q.count  <= COUNT_W'(cnt_q);
      if (cnt_q == '0) begin
        out_q.front_value <= '0;
        out_q.back_value  <= '0;
      end else begin
        out_q.front_value <= byp_front_q ? wdata_q : rd_front_q;
        out_q.back_value  <= byp_back_q ? wdata_q : rd_back_q;
      end
    end
  end

  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[rtl/core/double_ended_queue_core.sv]
// Bounded double-ended queue of signed 32-bit values held in a ring buffer of
// DEPTH entries (16). Each input transfer carries a command (push back, push
// front, pop back, pop front, clear) and a value; each yields exactly one
// result: status (ok, empty on a pop of an empty queue, full on a refused
// push), front and back values after the step (zero when empty) and the entry
// count. In the execution stage an item first updates the ring indices and
// count, writes the entry memory and launches its two registered reads, then
// loads the result register. Up to two decoded items wait in a queue ahead of
// execution, so input transfers are taken while a result is still waiting to
// be read. No clearing pass after reset.
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Top level: decode front end, operation queue and execution back end.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_core (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire  dq_pkg::in_item_t in_i,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  output dq_pkg::out_item_t    out_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i
);
  import dq_pkg::*;
  `include "assert_macros.svh"

  op_t  fe_op, bk_op;
  logic fe_valid, fe_ready;
  logic bk_valid, bk_ready;
  logic rsp_full, rsp_empty;

  dq_front u_front (
    .in_i       (in_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_o       (fe_op),
    .op_valid_o (fe_valid),
    .op_ready_i (fe_ready)
  );

  dq_op_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_op_i    (fe_op),
    .wr_valid_i (fe_valid),
    .wr_ready_o (fe_ready),
    .rd_op_o    (bk_op),
    .rd_valid_o (bk_valid),
    .rd_ready_i (bk_ready)
  );

  dq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (bk_op),
    .op_valid_i  (bk_valid),
    .op_ready_o  (bk_ready),
    .out_o       (out_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

  assign rsp_full  = out_valid_o && (out_o.status == ST_FULL);
  assign rsp_empty = out_valid_o && (out_o.status == ST_EMPTY);

  `DQ_ASSERT(a_full_count, rsp_full |-> (out_o.count == COUNT_W'(DEPTH)), "full below capacity")
  `DQ_ASSERT(a_empty_count, rsp_empty |-> (out_o.count == '0), "empty status with nonzero count")
  `DQ_ASSERT_NEVER(a_status_code, out_valid_o && out_o.status > ST_FULL, "undefined status code")

endmodule

`default_nettype wire

[test/deque_checker.sv]
// ----------------------------------------------------------------------------
// deque_checker
// Watches both channels of the deque core. Every input transfer is run through
// a cycle-free copy of the ring buffer, and the result it must give is queued.
// Each output transfer is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module deque_checker (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  dq_pkg::in_item_t  in_i,
  input  wire               in_valid_i,
  input  wire               in_ready_i,
  input  dq_pkg::out_item_t out_i,
  input  wire               out_valid_i,
  input  wire               out_ready_i,
  output int                fail_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import dq_pkg::*;

  logic signed [31:0] ring_mem [DEPTH];
  logic [IDX_W-1:0]   head_idx;
  logic [IDX_W-1:0]   tail_idx;
  logic [CNT_W-1:0]   held;

  out_item_t          awaited_results [$];
  out_item_t          oldest;

  // Applies one command to the model ring and returns the result it yields.
  function automatic out_item_t deque_apply(input in_item_t item);
    out_item_t res;
    res.status = ST_OK;
    case (item.cmd)
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        if (held == CNT_W'(DEPTH)) begin
          res.status = ST_FULL;
        end else if (held == '0) begin
          head_idx = tail_idx;
          ring_mem[tail_idx] = item.value;
          held = CNT_W'(1);
        end else if (item.cmd == CMD_PUSH_BACK) begin
          tail_idx = (tail_idx == IDX_W'(DEPTH - 1)) ? '0 : tail_idx + 1'b1;
          ring_mem[tail_idx] = item.value;
          held = held + 1'b1;
        end else begin
          head_idx = (head_idx == '0) ? IDX_W'(DEPTH - 1) : head_idx - 1'b1;
          ring_mem[head_idx] = item.value;
          held = held + 1'b1;
        end
      end
      CMD_POP_BACK: begin
        if (held == '0) begin
          res.status = ST_EMPTY;
        end else begin
          held = held - 1'b1;
          if (held != '0) tail_idx = (tail_idx == '0) ? IDX_W'(DEPTH - 1) : tail_idx - 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (held == '0) begin
          res.status = ST_EMPTY;
        end else begin
          held = held - 1'b1;
          if (held != '0) head_idx = (head_idx == IDX_W'(DEPTH - 1)) ? '0 : head_idx + 1'b1;
        end
      end
      CMD_CLEAR: begin
        held     = '0;
        head_idx = '0;
        tail_idx = '0;
      end
      default: ;  // unused codes leave the queue alone
    endcase
    if (held != '0) begin
      res.front_value = ring_mem[head_idx];
      res.back_value  = ring_mem[tail_idx];
    end else begin
      res.front_value = '0;
      res.back_value  = '0;
    end
    res.count = COUNT_W'(held);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%08h, actual 0x%08h", name, want, got);
      fail_count_o = fail_count_o + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_idx  = '0;
      tail_idx  = '0;
      held      = '0;
      awaited_results.delete();
      pending_o = 0;
    end else begin
      // result side first: a result never belongs to an item taken this edge
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with nothing outstanding: %p", out_i);
          fail_count_o = fail_count_o + 1;
        end else begin
          oldest = awaited_results.pop_front();
          check_field("status", 32'(oldest.status), 32'(out_i.status));
          check_field("front_value", oldest.front_value, out_i.front_value);
          check_field("back_value", oldest.back_value, out_i.back_value);
          check_field("count", 32'(oldest.count), 32'(out_i.count));
        end
      end
      if (in_valid_i && in_ready_i) awaited_results.push_back(deque_apply(in_i));
      pending_o = awaited_results.size();
    end
  end

endmodule

[test/tb_double_ended_queue_core.sv]
// ----------------------------------------------------------------------------
// tb_double_ended_queue_core
// Drives the deque core with a directed opening (empty pops, fill to full,
// refused pushes, unused codes, clear) and then phases of random commands
// biased toward filling, draining or balance, with bursty gaps on both sides.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_core;
  timeunit 1ns;
  timeprecision 1ps;

  import dq_pkg::*;

  localparam int         IDLE_LIMIT = 1000;
  localparam int         PHASES     = 20;
  localparam int         PHASE_LEN  = 100;
  localparam int         QUIET_FROM = 17;
  localparam logic [2:0] CMD_RSVD_A = 3'd5;
  localparam logic [2:0] CMD_RSVD_B = 3'd6;
  localparam logic [2:0] CMD_RSVD_C = 3'd7;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  in_item_t  in_item   = '0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  out_item_t out_item;
  logic      out_valid;
  logic      out_ready = 1'b0;

  logic      in_took   = 1'b0;
  bit        quiet     = 1'b0;
  int        gap_odds  = 4;
  int        stall_odds = 4;
  int        idle_cycles = 0;
  int        fail_count;
  int        pending;

  double_ended_queue_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_item),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .out_o       (out_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready)
  );

  deque_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_item),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .out_i        (out_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // registered so the driver can look at it on the falling edge
  always @(posedge clk_i) begin
    in_took <= in_valid && in_ready;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $error("no transfer for %0d cycles", IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // result side back-pressure, in bursts
  initial begin
    @(posedge rst_ni);
    forever begin
      if (!quiet && $urandom_range(0, 15) < stall_odds) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk_i);
      end
    end
  end

  task automatic send_item(input logic [2:0] cmd, input logic signed [31:0] value);
    in_item_t item;
    item.cmd   = cmd;
    item.value = value;
    in_item  <= item;
    in_valid <= 1'b1;
    do @(negedge clk_i); while (!in_took);
    if (!quiet && $urandom_range(0, 15) < gap_odds) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
  endtask

  // the last item was already taken, so valid drops before waiting
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    logic [2:0]         cmd;
    logic signed [31:0] value;
    int                 push_pct;
    int                 pick;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_item(CMD_POP_BACK, $urandom());
    send_item(CMD_POP_FRONT, $urandom());
    send_item(CMD_RSVD_A, $urandom());
    // fill to capacity from both ends; extremes go in first
    for (int i = 0; i < DEPTH; i++) begin
      case (i)
        0:       value = 32'sh7FFF_FFFF;
        1:       value = 32'sh8000_0000;
        2:       value = '0;
        3:       value = -32'sd1;
        default: value = $urandom();
      endcase
      send_item((i % 2 == 0) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, value);
    end
    send_item(CMD_PUSH_BACK, $urandom());
    send_item(CMD_PUSH_FRONT, $urandom());
    send_item(CMD_RSVD_B, $urandom());
    send_item(CMD_RSVD_C, $urandom());
    send_item(CMD_POP_FRONT, $urandom());
    send_item(CMD_POP_BACK, $urandom());
    send_item(CMD_CLEAR, $urandom());

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase % 5 == 4 && phase < QUIET_FROM) wait_drained();
      quiet      = (phase >= QUIET_FROM);
      gap_odds   = (phase % 4) * 3;
      stall_odds = ((phase + 2) % 4) * 3;
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      for (int n = 0; n < PHASE_LEN; n++) begin
        pick = $urandom_range(0, 99);
        if (pick == 0) begin
          cmd = CMD_CLEAR;
        end else if (pick < 3) begin
          cmd = 3'($urandom_range(CMD_RSVD_A, CMD_RSVD_C));
        end else if ($urandom_range(0, 99) < push_pct) begin
          cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        end else begin
          cmd = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
        end
        case ($urandom_range(0, 9))
          0:       value = 32'sh7FFF_FFFF;
          1:       value = 32'sh8000_0000;
          2:       value = '0;
          3:       value = -32'sd1;
          default: value = $urandom();
        endcase
        send_item(cmd, value);
      end
    end

    wait_drained();
    repeat (10) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/dq_pkg.sv
rtl/core/dq_front.sv
rtl/core/dq_op_queue.sv
rtl/core/dq_back.sv
rtl/core/double_ended_queue_core.sv
test/deque_checker.sv
test/tb_double_ended_queue_core.sv
